// ===== rtl/core/oflmmse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oflmmse_pkg: shared types and constants
// Field widths, register codes and the default register values of the
// pilot-based channel estimator and equalizer.
// ----------------------------------------------------------------------------
package oflmmse_pkg;

  localparam int SampleW  = 16;
  localparam int ChanW    = 24;
  localparam int NoiseW   = 32;
  localparam int ScW      = 6;
  localparam int SlotW    = 2;
  localparam int NumW     = 41;   // |num| < 2^41
  localparam int DenW     = 50;   // den < 2^50
  localparam int DivW     = 59;   // |num| << 17 plus headroom
  localparam int QW       = 17;   // quotient bits that decide saturation

  localparam int DefSubcarriers = 64;
  localparam int DefPilots      = 4;

  localparam logic [15:0] WeightReset = 16'd8192;
  localparam logic [31:0] NoiseReset  = 32'd167772;

  localparam logic signed [ChanW-1:0] ChanMax = 24'sh7FFFFF;
  localparam logic signed [ChanW-1:0] ChanMin = 24'sh800000;

  // Register addresses, word index.
  typedef enum logic [2:0] {
    REG_WEIGHT0 = 3'd0,
    REG_WEIGHT1 = 3'd1,
    REG_WEIGHT2 = 3'd2,
    REG_WEIGHT3 = 3'd3,
    REG_NOISE   = 3'd4
  } reg_idx_t;

  typedef enum logic {
    CMD_PILOT = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MULT,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  // Start request for the divider.
  typedef struct packed {
    logic                 start;
    logic [NumW-1:0]      mag_re;
    logic                 neg_re;
    logic [NumW-1:0]      mag_im;
    logic                 neg_im;
    logic [DenW-1:0]      den;
  } div_req_t;

  // Divider status.
  typedef struct packed {
    logic                       done;
    logic                       busy;
    logic signed [SampleW-1:0]  q_re;
    logic signed [SampleW-1:0]  q_im;
    logic                       clip;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/oflmmse_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oflmmse_ram: generic single-port synchronous RAM
// One access a cycle, a write also returning the old word; the read data is registered.
// ----------------------------------------------------------------------------
module oflmmse_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output      logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Read before write, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/oflmmse_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oflmmse_div: restoring divider for the equalizer quotient
// Computes round(|num| * 2^17 / den) for both parts, one bit a cycle, both
// parts side by side, then applies sign and saturation.
// ----------------------------------------------------------------------------
module oflmmse_div
  import oflmmse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output      div_rsp_t rsp
);

  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0]  dvd_re, dvd_im;   // shifting dividend
  logic [DenW:0]    rem_re, rem_im;   // partial remainder
  logic [DivW-1:0]  quo_re, quo_im;
  logic [DenW-1:0]  den;
  logic             neg_re, neg_im, zero;
  logic [CntW-1:0]  cnt;
  logic             busy, fin;

  logic [DenW:0]    tr_re, tr_im;
  logic             ge_re, ge_im;
  logic [DivW:0]    rq_re, rq_im;     // rounded quotients
  logic             sat_re, sat_im;
  logic signed [SampleW-1:0] o_re, o_im;

  // One trial subtraction per part.
  always_comb begin
    tr_re = {rem_re[DenW-1:0], dvd_re[DivW-1]};
    tr_im = {rem_im[DenW-1:0], dvd_im[DivW-1]};
    ge_re = tr_re >= {1'b0, den};
    ge_im = tr_im >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DivW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend is 2*|num|*2^17 + den, divided by 2*den, which
  // equals (|num|*2^17 + den/2) / den for integer results.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_re <= DivW'({req.mag_re, 18'd0}) + DivW'(req.den);
      dvd_im <= DivW'({req.mag_im, 18'd0}) + DivW'(req.den);
      den    <= req.den;
      rem_re <= '0;
      rem_im <= '0;
      quo_re <= '0;
      quo_im <= '0;
      neg_re <= req.neg_re;
      neg_im <= req.neg_im;
      zero   <= req.den == '0;
    end else if (busy) begin
      dvd_re <= {dvd_re[DivW-2:0], 1'b0};
      dvd_im <= {dvd_im[DivW-2:0], 1'b0};
      rem_re <= ge_re ? tr_re - {1'b0, den} : tr_re;
      rem_im <= ge_im ? tr_im - {1'b0, den} : tr_im;
      quo_re <= {quo_re[DivW-2:0], ge_re};
      quo_im <= {quo_im[DivW-2:0], ge_im};
    end
  end

  // quo holds (2*|num|*2^17 + den) / den; halve it to get the rounded value.
  always_comb begin
    rq_re  = {2'b0, quo_re[DivW-1:1]};
    rq_im  = {2'b0, quo_im[DivW-1:1]};
    sat_re = neg_re ? (rq_re > (DivW+1)'(32768)) : (rq_re > (DivW+1)'(32767));
    sat_im = neg_im ? (rq_im > (DivW+1)'(32768)) : (rq_im > (DivW+1)'(32767));
    if (sat_re) o_re = neg_re ? -16'sd32768 : 16'sd32767;
    else        o_re = neg_re ? -$signed(rq_re[SampleW-1:0]) : $signed(rq_re[SampleW-1:0]);
    if (sat_im) o_im = neg_im ? -16'sd32768 : 16'sd32767;
    else        o_im = neg_im ? -$signed(rq_im[SampleW-1:0]) : $signed(rq_im[SampleW-1:0]);
    rsp.done = fin;
    rsp.busy = busy;
    rsp.q_re = zero ? '0 : o_re;
    rsp.q_im = zero ? '0 : o_im;
    rsp.clip = zero ? 1'b0 : (sat_re | sat_im);
  end

`ifndef SYNTHESIS
  a_fin_after_busy: assert property (@(posedge clk) disable iff (rst)
    fin |-> $past(busy)) else $error("divider finished without running");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start) else $error("divider restarted while busy");
  a_fin_pulse: assert property (@(posedge clk) disable iff (rst)
    fin |=> !fin) else $error("divider done held longer than a cycle");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ofdm_ls_estimate_lmmse_equalize.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ofdm_ls_estimate_lmmse_equalize: pilot LS channel estimate, LMMSE equalizer
// Keeps one complex channel estimate per subcarrier in a RAM, built from
// weighted pilots, and equalizes data words as y*conj(H)/(|H|^2+noise).
// ----------------------------------------------------------------------------
// A pilot word passes the states RAM read, multiply, and add and write back.
// A data word passes the same read, multiply and sum states, then the bit-serial
// divider, which produces 59 quotient bits for both parts in parallel, and
// then waits until the output register is free. After reset the channel
// RAM is cleared, one entry a cycle, before the first word is taken. The
// result word sits in an output register; the next input word is taken
// while it waits. Configuration writes are accepted at any time with pready
// tied high.
module ofdm_ls_estimate_lmmse_equalize
  import oflmmse_pkg::*;
#(
  parameter int SUBCARRIERS = DefSubcarriers,
  parameter int PILOTS      = DefPilots
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input: cmd[0], subcarrier[6:1], pilot_slot[8:7], sample_re[24:9],
  // sample_im[40:25], zero fill to 48 bits.
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [47:0] s_tdata,
  // Output: out_subcarrier[5:0], eq_re[21:6], eq_im[37:22], clipped[38],
  // zero fill to 40 bits.
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int AddrW = (SUBCARRIERS > 1) ? $clog2(SUBCARRIERS) : 1;

  // Configuration registers.
  logic [15:0] weight [4];
  logic [31:0] noise;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) weight[i] <= WeightReset;
      noise <= NoiseReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (ridx == REG_NOISE) noise <= pwdata;
      else if (ridx <= REG_WEIGHT3) weight[ridx[1:0]] <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (ridx)
      REG_WEIGHT0, REG_WEIGHT1, REG_WEIGHT2, REG_WEIGHT3:
        prdata = {{16{weight[ridx[1:0]][15]}}, weight[ridx[1:0]]};
      REG_NOISE: prdata = noise;
      default:   prdata = '0;
    endcase
  end

  // Word fields.
  logic                      in_cmd;
  logic [ScW-1:0]            in_sc;
  logic [SlotW-1:0]          in_slot;
  logic signed [SampleW-1:0] in_re, in_im;
  logic                      in_ok;

  assign in_cmd  = s_tdata[0];
  assign in_sc   = s_tdata[6:1];
  assign in_slot = s_tdata[8:7];
  assign in_re   = s_tdata[24:9];
  assign in_im   = s_tdata[40:25];
  assign in_ok   = (32'(in_sc) < SUBCARRIERS) &&
                   (in_cmd == CMD_DATA || 32'(in_slot) < PILOTS);

  // Control.
  state_t state, state_next;
  logic [AddrW:0] clr_cnt;
  logic           clearing;
  logic           accept;
  div_req_t       dreq;
  div_rsp_t       drsp;

  logic                      r_cmd;
  logic [ScW-1:0]            r_sc;
  logic [SlotW-1:0]          r_slot;
  logic signed [SampleW-1:0] r_re, r_im;

  assign clearing = clr_cnt != (AddrW+1)'(SUBCARRIERS);
  assign s_tready = !clearing && state == ST_IDLE;
  assign accept   = s_tvalid && s_tready;

  // Output register.
  logic        ov;
  logic [38:0] opay;
  logic        out_free;

  assign out_free = !ov || m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && in_ok) state_next = ST_READ;
      ST_READ: state_next = ST_MULT;
      ST_MULT: state_next = ST_SUM;
      ST_SUM:  state_next = (r_cmd == CMD_DATA) ? ST_DIV : ST_IDLE;
      ST_DIV:  if (drsp.done) state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_cmd  <= in_cmd;
      r_sc   <= in_sc;
      r_slot <= in_slot;
      r_re   <= in_re;
      r_im   <= in_im;
    end
  end

  // Channel RAM: {re, im}.
  logic                     ram_we;
  logic [AddrW-1:0]         ram_addr;
  logic [2*ChanW-1:0]       ram_wdata, ram_rdata;
  logic signed [ChanW-1:0]  h_re, h_im, n_re, n_im;

  oflmmse_ram #(.Width(2*ChanW), .Depth(SUBCARRIERS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Multiply stage (one product set, registered).
  logic signed [31:0]        p_wre, p_wim;
  logic signed [40:0]        p_rr, p_ii, p_ir, p_ri;
  logic [47:0]               p_hh0, p_hh1;
  logic signed [ChanW-1:0]   hq_re, hq_im;
  logic signed [15:0]        wsel;

  assign wsel = weight[r_slot];

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      hq_re <= ram_rdata[2*ChanW-1:ChanW];
      hq_im <= ram_rdata[ChanW-1:0];
    end
    if (state == ST_MULT) begin
      p_wre <= r_re * wsel;
      p_wim <= r_im * wsel;
      p_rr  <= 41'(r_re * hq_re);
      p_ii  <= 41'(r_im * hq_im);
      p_ir  <= 41'(r_im * hq_re);
      p_ri  <= 41'(r_re * hq_im);
      p_hh0 <= 48'(hq_re * hq_re);
      p_hh1 <= 48'(hq_im * hq_im);
    end
  end

  // Pilot accumulate, rounded half up then saturated.
  logic signed [ChanW+8:0] t_re, t_im, s_re, s_im;

  always_comb begin
    t_re = 33'((40'(p_wre) + 40'sd512) >>> 10);
    t_im = 33'((40'(p_wim) + 40'sd512) >>> 10);
    s_re = (r_slot == '0) ? t_re : t_re + 33'(h_re);
    s_im = (r_slot == '0) ? t_im : t_im + 33'(h_im);
    n_re = (s_re > 33'(ChanMax)) ? ChanMax : (s_re < 33'(ChanMin)) ? ChanMin : s_re[ChanW-1:0];
    n_im = (s_im > 33'(ChanMax)) ? ChanMax : (s_im < 33'(ChanMin)) ? ChanMin : s_im[ChanW-1:0];
  end

  assign h_re = hq_re;
  assign h_im = hq_im;

  always_comb begin
    ram_we    = clearing || (state == ST_SUM && r_cmd == CMD_PILOT);
    ram_addr  = clearing ? clr_cnt[AddrW-1:0] :
                (state == ST_IDLE) ? in_sc[AddrW-1:0] : r_sc[AddrW-1:0];
    ram_wdata = clearing ? '0 : {n_re, n_im};
  end

  // Numerator and denominator, then divider start.
  logic signed [NumW:0] num_re, num_im;

  always_comb begin
    num_re = 42'(p_rr) + 42'(p_ii);
    num_im = 42'(p_ir) - 42'(p_ri);
    dreq.start  = state == ST_SUM && r_cmd == CMD_DATA;
    dreq.neg_re = num_re[NumW];
    dreq.neg_im = num_im[NumW];
    dreq.mag_re = NumW'(num_re[NumW] ? -num_re : num_re);
    dreq.mag_im = NumW'(num_im[NumW] ? -num_im : num_im);
    dreq.den    = DenW'(p_hh0) + DenW'(p_hh1) + {2'b0, noise, 16'd0};
  end

  oflmmse_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Result hold and output register.
  logic [38:0] res;

  always_ff @(posedge clk) begin
    if (drsp.done) res <= {drsp.clip, drsp.q_im, drsp.q_re, r_sc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      ov <= 1'b1;
    end else if (m_tready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) opay <= res;
  end

  assign m_tvalid = ov;
  assign m_tdata  = {1'b0, opay};

`ifndef SYNTHESIS
  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready) else $error("word taken during clear");
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == ST_DIV) else $error("divider done outside divide");
  a_wr_pilot: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !clearing) |-> r_cmd == CMD_PILOT) else $error("bad RAM write");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/ofdm_ls_estimate_lmmse_equalize_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ofdm_ls_estimate_lmmse_equalize_test: self-checking testbench
// Drives pilot and data words with random gaps and stalls, writes the weight
// and noise registers between phases, and checks every equalized word against
// a channel estimator and equalizer modeled in the testbench.
// ----------------------------------------------------------------------------
`default_nettype none

module ofdm_ls_estimate_lmmse_equalize_test;
  import oflmmse_pkg::*;

  // Expected equalized word.
  typedef struct {
    logic [5:0]  sc;
    logic [15:0] re;
    logic [15:0] im;
    logic        clip;
  } eq_word_t;

  int err_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // Channel estimator and equalizer with its own copy of state and registers.
  class eq_scoreboard;
    logic signed [15:0] weight[4];
    logic [31:0]        noise;
    logic signed [23:0] ch_re[64];
    logic signed [23:0] ch_im[64];
    eq_word_t           pending[$];

    function new();
      for (int i = 0; i < 4; i++) weight[i] = WeightReset;
      noise = NoiseReset;
      for (int i = 0; i < 64; i++) begin
        ch_re[i] = '0;
        ch_im[i] = '0;
      end
    endfunction

    function automatic longint pilot_term(longint p);
      return (p + 512) >>> 10;
    endfunction

    function automatic longint sat24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function automatic logic [15:0] div_round(longint num, logic [63:0] den,
                                              ref logic clip);
      logic [63:0] mag, q;
      if (den == 0) return '0;
      mag = (num < 0) ? -num : num;
      q = ((mag << 17) + den / 2) / den;
      if (num < 0) begin
        if (q > 32768) begin
          clip = 1'b1;
          return 16'h8000;
        end
        return 16'(-q);
      end
      if (q > 32767) begin
        clip = 1'b1;
        return 16'h7FFF;
      end
      return 16'(q);
    endfunction

    function automatic void note_input(logic [47:0] d);
      logic [5:0] sc;
      logic [1:0] slot;
      longint yr, yi, hr, hi, w, tr, ti, nre, nim;
      logic [63:0] den;
      eq_word_t e;
      sc   = d[6:1];
      slot = d[8:7];
      yr   = $signed(d[24:9]);
      yi   = $signed(d[40:25]);
      hr   = ch_re[sc];
      hi   = ch_im[sc];
      if (d[0] == CMD_PILOT) begin
        w  = weight[slot];
        tr = pilot_term(yr * w);
        ti = pilot_term(yi * w);
        if (slot != 0) begin
          tr = sat24(tr + hr);
          ti = sat24(ti + hi);
        end
        ch_re[sc] = 24'(tr);
        ch_im[sc] = 24'(ti);
        return;
      end
      nre = yr * hr + yi * hi;
      nim = yi * hr - yr * hi;
      den = hr * hr + hi * hi + (64'(noise) << 16);
      e.sc = sc;
      e.clip = 1'b0;
      e.re = div_round(nre, den, e.clip);
      e.im = div_round(nim, den, e.clip);
      pending.push_back(e);
    endfunction

    task automatic check_result(logic [39:0] d);
      eq_word_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", d, 0);
        return;
      end
      e = pending.pop_front();
      if (d[5:0] !== e.sc) report_mismatch("out_subcarrier", d[5:0], e.sc);
      if (d[21:6] !== e.re) report_mismatch("eq_re", d[21:6], e.re);
      if (d[37:22] !== e.im) report_mismatch("eq_im", d[37:22], e.im);
      if (d[38] !== e.clip) report_mismatch("clipped", d[38], e.clip);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  eq_scoreboard eq_sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 1'b0;
  int  quiet_cycles = 0;

  ofdm_ls_estimate_lmmse_equalize u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold when asked.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) eq_sb.check_result(m_tdata);
    m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("ofdm_ls_estimate_lmmse_equalize_test: done, errors");
        $finish;
      end
    end
  end

  // Offers one word; tvalid stays high after the handshake until the next
  // idle gap or a drain takes it down, or the next word replaces it.
  task automatic send_word(input logic cmd, input logic [5:0] sc, input logic [1:0] slot,
                           input logic [15:0] yr, input logic [15:0] yi);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, yi, yr, slot, sc, cmd};
    do @(posedge clk); while (!s_tready);
    eq_sb.note_input({7'd0, yi, yr, slot, sc, cmd});
  endtask

  // Waits until every expected word has arrived, then lets a pilot finish.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (eq_sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_NOISE) eq_sb.noise = val;
    else eq_sb.weight[idx] = val[15:0];
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly full pilot bursts on a subcarrier, then data on it; some noise.
  task automatic random_items(input int n);
    logic [5:0] sc;
    for (int i = 0; i < n; i++) begin
      sc = 6'($urandom_range(63));
      if ($urandom_range(3) == 0) begin
        send_word(logic'($urandom), sc, 2'($urandom), rand_sample(), rand_sample());
      end else begin
        for (int s = 0; s < 4; s++) send_word(CMD_PILOT, sc, 2'(s), rand_sample(), rand_sample());
        send_word(CMD_DATA, sc, 2'($urandom), rand_sample(), rand_sample());
        i += 4;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, both commands, zero estimate, saturation.
    send_word(CMD_DATA, 6'd0, 2'd0, 16'h7FFF, 16'h8000);
    send_word(CMD_PILOT, 6'd63, 2'd0, 16'h7FFF, 16'h8000);
    send_word(CMD_DATA, 6'd63, 2'd3, 16'h7FFF, 16'h7FFF);
    send_word(CMD_PILOT, 6'd1, 2'd0, 16'h8000, 16'h8000);
    send_word(CMD_DATA, 6'd1, 2'd0, 16'h8000, 16'h0001);
    drain();
    write_reg(REG_WEIGHT0, 32'h7FFF);
    write_reg(REG_WEIGHT1, 32'h7FFF);
    write_reg(REG_WEIGHT2, 32'h8000);
    write_reg(REG_WEIGHT3, 32'h7FFF);
    write_reg(REG_NOISE, 32'd1);
    for (int s = 0; s < 4; s++) send_word(CMD_PILOT, 6'd5, 2'(s), 16'h7FFF, 16'h7FFF);
    send_word(CMD_DATA, 6'd5, 2'd0, 16'h7FFF, 16'h8000);
    for (int s = 1; s < 4; s++) send_word(CMD_PILOT, 6'd6, 2'(s), 16'h8000, 16'h8000);
    send_word(CMD_DATA, 6'd6, 2'd0, 16'h0001, 16'hFFFF);
    send_word(CMD_DATA, 6'd7, 2'd0, 16'h7FFF, 16'h8000);
    drain();
    write_reg(REG_NOISE, 32'hFFFFFFFF);
    send_word(CMD_DATA, 6'd5, 2'd0, 16'h7FFF, 16'h8000);
    send_word(CMD_DATA, 6'd2, 2'd0, 16'h1234, 16'h4321);
    drain();

    // Phase 1: sender idles often, random weights.
    for (int r = 0; r < 4; r++) write_reg(reg_idx_t'(r), $urandom);
    write_reg(REG_NOISE, $urandom_range(1 << 20, 1));
    send_idle_pct = 38;
    recv_idle_pct = 48;
    random_items(240);
    drain();

    // Receiver holds off while the sender keeps offering words.
    fork
      begin
        recv_hold = 1'b1;
        repeat (600) @(posedge clk);
        recv_hold = 1'b0;
      end
    join_none
    random_items(40);
    drain();

    // Phase 2: other way round, default-like weights.
    for (int r = 0; r < 4; r++) write_reg(reg_idx_t'(r), 32'h2000 + $urandom_range(4096));
    write_reg(REG_NOISE, $urandom);
    send_idle_pct = 48;
    recv_idle_pct = 38;
    random_items(230);
    drain();

    // Phase 3: no idling.
    write_reg(REG_NOISE, 32'd167772);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(230);
    drain();

    if (err_count == 0) begin
      $display("ofdm_ls_estimate_lmmse_equalize_test: done, clean");
    end else begin
      $display("ofdm_ls_estimate_lmmse_equalize_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/oflmmse_pkg.sv
rtl/core/oflmmse_ram.sv
rtl/core/oflmmse_div.sv
rtl/core/ofdm_ls_estimate_lmmse_equalize.sv
tb/sv/ofdm_ls_estimate_lmmse_equalize_test.sv
